// ===== sv/brb_pkg.sv =====
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the byte ring buffer core.
// ----------------------------------------------------------------------------
package brb_pkg;

    localparam int DEPTH_DEFAULT     = 1024;
    localparam int MAX_BURST_DEFAULT = 64;

    // Fixed field widths of the ports.
    localparam int MODE_W = 2;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int CFG_W  = 11;
    localparam int OCC_W  = 11;

    localparam logic [MODE_W-1:0] MODE_PUT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GET  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK = 2'd2;

    // Commands from the controller to the datapath for one cycle.
    typedef struct packed {
        logic put;        // store write_byte if there is room
        logic null_res;   // emit one result without a byte
        logic rd;         // read one byte and emit it
        logic from_scan;  // read at the scan pointer instead of the read pointer
        logic remove;     // the byte read is removed (get)
        logic last;       // the result ends the transaction's run
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [LEN_W-1:0] avail;  // held bytes, clipped to the burst limit
    } status_t;

endpackage

// ===== sv/brb_ctrl.sv =====
// ----------------------------------------------------------------------------
// brb_ctrl
// Controller: decodes a transaction and sequences the bytes of a burst.
// ----------------------------------------------------------------------------
module brb_ctrl #(
    parameter int MAX_BURST = brb_pkg::MAX_BURST_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [brb_pkg::MODE_W-1:0]   mode,
    input  logic [brb_pkg::LEN_W-1:0]    request_length,
    input  brb_pkg::status_t             status,
    output logic                         busy,
    output brb_pkg::cmd_t                cmd
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_BURST = 2'b10
    } state_t;

    state_t                      state_reg, state_next;
    logic [brb_pkg::LEN_W-1:0]   remain_reg, remain_next;
    logic                        remove_reg, remove_next;
    logic [brb_pkg::LEN_W-1:0]   req_clip;
    logic [brb_pkg::LEN_W-1:0]   burst_len;

    always_comb
    begin
        req_clip  = (request_length > brb_pkg::LEN_W'(MAX_BURST)) ?
                    brb_pkg::LEN_W'(MAX_BURST) : request_length;
        burst_len = (req_clip < status.avail) ? req_clip : status.avail;
    end

    always_comb
    begin
        state_next  = state_reg;
        remain_next = remain_reg;
        remove_next = remove_reg;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (mode) inside
                        brb_pkg::MODE_PUT:
                        begin
                            cmd.put = 1'b1;
                        end
                        brb_pkg::MODE_GET, brb_pkg::MODE_PEEK:
                        begin
                            if (burst_len == '0)
                            begin
                                cmd.null_res = 1'b1;
                            end
                            else
                            begin
                                // The first byte is read in the accepting cycle.
                                cmd.rd      = 1'b1;
                                cmd.remove  = (mode == brb_pkg::MODE_GET);
                                cmd.last    = (burst_len == brb_pkg::LEN_W'(1));
                                remove_next = (mode == brb_pkg::MODE_GET);
                                remain_next = burst_len - brb_pkg::LEN_W'(1);
                                if (burst_len != brb_pkg::LEN_W'(1))
                                begin
                                    state_next = ST_BURST;
                                end
                            end
                        end
                        default:
                        begin
                            cmd.null_res = 1'b1;
                        end
                    endcase
                end
            end
            ST_BURST:
            begin
                cmd.rd        = 1'b1;
                cmd.from_scan = 1'b1;
                cmd.remove    = remove_reg;
                cmd.last      = (remain_reg == brb_pkg::LEN_W'(1));
                remain_next   = remain_reg - brb_pkg::LEN_W'(1);
                if (remain_reg == brb_pkg::LEN_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg == ST_BURST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            remain_reg <= '0;
            remove_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
            remove_reg <= remove_next;
        end
    end

endmodule

// ===== sv/brb_datapath.sv =====
// ----------------------------------------------------------------------------
// brb_datapath
// Byte store, pointers, occupancy count, capacity register and result regs.
// ----------------------------------------------------------------------------
module brb_datapath #(
    parameter int DEPTH     = brb_pkg::DEPTH_DEFAULT,
    parameter int MAX_BURST = brb_pkg::MAX_BURST_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  brb_pkg::cmd_t                cmd,
    input  logic [brb_pkg::BYTE_W-1:0]   write_byte,
    input  logic                         cfg_wr,
    input  logic [brb_pkg::CFG_W-1:0]    cfg_data,
    output brb_pkg::status_t             status,
    output logic                         result_strobe,
    output logic [brb_pkg::BYTE_W-1:0]   read_byte,
    output logic                         byte_valid,
    output logic                         put_accepted,
    output logic                         last_of_run,
    output logic [brb_pkg::OCC_W-1:0]    occupancy,
    output logic                         is_empty,
    output logic                         is_full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > brb_pkg::CFG_W) ? CNT_W : brb_pkg::CFG_W;

    logic [brb_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [brb_pkg::BYTE_W-1:0] rdata_reg;

    logic [CNT_W-1:0] capacity_reg, capacity_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] scan_ptr_reg, scan_ptr_next;

    logic             strobe_reg;
    logic             valid_reg, accepted_reg, last_reg;
    logic             empty_reg, full_reg;
    logic [brb_pkg::OCC_W-1:0] occ_reg;

    logic [CMP_W-1:0] cfg_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] occ_ext;
    logic [PTR_W-1:0] rd_addr;
    logic [CNT_W-1:0] rd_inc, wr_inc;
    logic [PTR_W-1:0] rd_wrap, wr_wrap;
    logic             room;
    logic             do_write;

    // Capacity is clamped to the range one to DEPTH.
    always_comb
    begin
        cfg_ext = CMP_W'(cfg_data);
        if (cfg_ext == '0)
        begin
            capacity_next = CNT_W'(1);
        end
        else if (cfg_ext > CMP_W'(DEPTH))
        begin
            capacity_next = CNT_W'(DEPTH);
        end
        else
        begin
            capacity_next = CNT_W'(cfg_ext);
        end
    end

    always_comb
    begin
        cnt_ext      = CMP_W'(count_reg);
        status.avail = (cnt_ext > CMP_W'(MAX_BURST)) ?
                       brb_pkg::LEN_W'(MAX_BURST) : brb_pkg::LEN_W'(count_reg);
    end

    // Pointer increments wrap at the configured capacity.
    always_comb
    begin
        room     = (count_reg < capacity_reg);
        do_write = cmd.put && room;
        rd_addr  = cmd.from_scan ? scan_ptr_reg : rd_ptr_reg;
        rd_inc   = CNT_W'(rd_addr) + CNT_W'(1);
        wr_inc   = CNT_W'(wr_ptr_reg) + CNT_W'(1);
        rd_wrap  = (rd_inc >= capacity_reg) ? '0 : rd_inc[PTR_W-1:0];
        wr_wrap  = (wr_inc >= capacity_reg) ? '0 : wr_inc[PTR_W-1:0];
    end

    always_comb
    begin
        count_next    = count_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        scan_ptr_next = scan_ptr_reg;
        if (do_write)
        begin
            wr_ptr_next = wr_wrap;
            count_next  = count_reg + CNT_W'(1);
        end
        if (cmd.rd)
        begin
            scan_ptr_next = rd_wrap;
            if (cmd.remove)
            begin
                rd_ptr_next = rd_wrap;
                count_next  = count_reg - CNT_W'(1);
            end
        end
        occ_ext = CMP_W'(count_next);
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[wr_ptr_reg] <= write_byte;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CNT_W'(DEPTH);
            count_reg    <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            scan_ptr_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            capacity_reg <= capacity_next;
            count_reg    <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            scan_ptr_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            scan_ptr_reg <= scan_ptr_next;
            strobe_reg   <= cmd.put || cmd.null_res || cmd.rd;
        end
    end

    always_ff @(posedge clk)
    begin
        valid_reg    <= cmd.rd;
        accepted_reg <= do_write;
        last_reg     <= cmd.put || cmd.null_res || cmd.last;
        occ_reg      <= occ_ext[brb_pkg::OCC_W-1:0];
        empty_reg    <= (count_next == '0);
        full_reg     <= (count_next == capacity_reg);
    end

    assign result_strobe = strobe_reg;
    assign read_byte     = valid_reg ? rdata_reg : '0;
    assign byte_valid    = valid_reg;
    assign put_accepted  = accepted_reg;
    assign last_of_run   = last_reg;
    assign occupancy     = occ_reg;
    assign is_empty      = empty_reg;
    assign is_full       = full_reg;

endmodule

// ===== sv/byte_ring_buffer_core.sv =====
// ----------------------------------------------------------------------------
// byte_ring_buffer_core
// Byte circular FIFO with a configurable capacity and put, get and peek.
// ----------------------------------------------------------------------------
// Each result is registered and appears in the cycle after the cycle that produced it.
// A put or empty request does not raise busy; a get or peek of more than one byte
// holds busy after acceptance until its last byte is read, one byte per cycle from
// the single read port of the byte store. Results cannot be stalled by the receiver.
// Reset clears pointers and count and sets capacity to DEPTH; the store
// itself is not cleared and needs no clearing pass.
module byte_ring_buffer_core #(
    parameter int DEPTH     = brb_pkg::DEPTH_DEFAULT,
    parameter int MAX_BURST = brb_pkg::MAX_BURST_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [brb_pkg::MODE_W-1:0]   mode,
    input  logic [brb_pkg::BYTE_W-1:0]   write_byte,
    input  logic [brb_pkg::LEN_W-1:0]    request_length,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [brb_pkg::CFG_W-1:0]    cfg_data,
    output logic                         result_strobe,
    output logic [brb_pkg::BYTE_W-1:0]   read_byte,
    output logic                         byte_valid,
    output logic                         put_accepted,
    output logic                         last_of_run,
    output logic [brb_pkg::OCC_W-1:0]    occupancy,
    output logic                         is_empty,
    output logic                         is_full
);

    brb_pkg::cmd_t    cmd;
    brb_pkg::status_t status;
    logic             cfg_wr;

    // A capacity write waits while a command is presented or a burst runs.
    assign cfg_ready = !busy && !start;
    assign cfg_wr    = cfg_valid && cfg_ready;

    brb_ctrl #(
        .MAX_BURST (MAX_BURST)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .mode           (mode),
        .request_length (request_length),
        .status         (status),
        .busy           (busy),
        .cmd            (cmd)
    );

    brb_datapath #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .write_byte    (write_byte),
        .cfg_wr        (cfg_wr),
        .cfg_data      (cfg_data),
        .status        (status),
        .result_strobe (result_strobe),
        .read_byte     (read_byte),
        .byte_valid    (byte_valid),
        .put_accepted  (put_accepted),
        .last_of_run   (last_of_run),
        .occupancy     (occupancy),
        .is_empty      (is_empty),
        .is_full       (is_full)
    );

endmodule

// ===== tb/byte_ring_buffer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_core_tb
// Self-checking bench for the byte ring buffer core. A queue-fed driver issues
// put, get, peek and unused-mode commands with random idle bursts. A clocked
// monitor predicts every result from its own copy of the FIFO and checks it.
// The run goes through several capacity settings, including zero and the top
// of the register range.
// ----------------------------------------------------------------------------
module byte_ring_buffer_core_tb;

    localparam logic [brb_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOWN_FAILURES = 10;

    typedef struct packed {
        logic [brb_pkg::MODE_W-1:0] mode;
        logic [brb_pkg::BYTE_W-1:0] data;
        logic [brb_pkg::LEN_W-1:0]  len;
    } fifo_cmd_t;

    // Field order matches the concatenation of result ports in the monitor.
    typedef struct packed {
        logic [brb_pkg::BYTE_W-1:0] rbyte;
        logic                       valid;
        logic                       accepted;
        logic                       last;
        logic [brb_pkg::OCC_W-1:0]  occ;
        logic                       empty;
        logic                       full;
    } fifo_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [brb_pkg::MODE_W-1:0]   mode = brb_pkg::MODE_PUT;
    logic [brb_pkg::BYTE_W-1:0]   write_byte = '0;
    logic [brb_pkg::LEN_W-1:0]    request_length = '0;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [brb_pkg::CFG_W-1:0]    cfg_data = '0;
    logic                         result_strobe;
    logic [brb_pkg::BYTE_W-1:0]   read_byte;
    logic                         byte_valid;
    logic                         put_accepted;
    logic                         last_of_run;
    logic [brb_pkg::OCC_W-1:0]    occupancy;
    logic                         is_empty;
    logic                         is_full;

    fifo_cmd_t    pending_cmds[$];
    fifo_result_t due_results[$];

    // Predicted FIFO contents and bookkeeping.
    logic [brb_pkg::BYTE_W-1:0] ring_mem [0:brb_pkg::DEPTH_DEFAULT-1];
    int unsigned       wr_idx = 0;
    int unsigned       rd_idx = 0;
    int unsigned       held = 0;
    int unsigned       cap = brb_pkg::DEPTH_DEFAULT;

    logic        start_taken = 1'b0;
    bit          quiet_tail = 1'b0;
    int unsigned gap_left = 0;
    int unsigned cycle_count = 0;
    int unsigned failure_count = 0;
    int unsigned results_checked = 0;
    int unsigned cap_writes = 0;
    int unsigned mode_hits [4] = '{0, 0, 0, 0};

    byte_ring_buffer_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .write_byte     (write_byte),
        .request_length (request_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .result_strobe  (result_strobe),
        .read_byte      (read_byte),
        .byte_valid     (byte_valid),
        .put_accepted   (put_accepted),
        .last_of_run    (last_of_run),
        .occupancy      (occupancy),
        .is_empty       (is_empty),
        .is_full        (is_full)
    );

    always #4 clk = ~clk;

    // Records one expected result; the status fields reflect the FIFO as it
    // stands after the effect of this result.
    task automatic post_result(input logic [brb_pkg::BYTE_W-1:0] rbyte, input logic valid,
                               input logic accepted, input logic last);
        fifo_result_t r;
        r.rbyte    = rbyte;
        r.valid    = valid;
        r.accepted = accepted;
        r.last     = last;
        r.occ      = held[brb_pkg::OCC_W-1:0];
        r.empty    = (held == 0);
        r.full     = (held == cap);
        due_results.push_back(r);
    endtask

    task automatic compute_ring_results(input fifo_cmd_t c);
        int unsigned n;
        int unsigned p;
        int unsigned i;
        if (c.mode == brb_pkg::MODE_PUT)
        begin
            if (held < cap)
            begin
                ring_mem[wr_idx] = c.data;
                wr_idx = (wr_idx + 1 >= cap) ? 0 : wr_idx + 1;
                held++;
                post_result('0, 1'b0, 1'b1, 1'b1);
            end
            else
                post_result('0, 1'b0, 1'b0, 1'b1);
        end
        else if (c.mode == MODE_UNUSED)
            post_result('0, 1'b0, 1'b0, 1'b1);
        else
        begin
            n = 32'(c.len);
            if (n > brb_pkg::MAX_BURST_DEFAULT)
                n = brb_pkg::MAX_BURST_DEFAULT;
            if (n > held)
                n = held;
            if (n == 0)
                post_result('0, 1'b0, 1'b0, 1'b1);
            p = rd_idx;
            for (i = 0; i < n; i++)
            begin
                // A peek walks a private pointer and leaves the count alone.
                if (c.mode == brb_pkg::MODE_GET)
                begin
                    rd_idx = (rd_idx + 1 >= cap) ? 0 : rd_idx + 1;
                    held--;
                end
                post_result(ring_mem[p], 1'b1, 1'b0, i + 1 == n);
                p = (p + 1 >= cap) ? 0 : p + 1;
            end
        end
    endtask

    task automatic report_failure(input string what);
        if (failure_count < SHOWN_FAILURES)
            $display("[%0t] mismatch: %s", $realtime, what);
        failure_count++;
    endtask

    // Driver: a command stays on the pins until the core takes it.
    always @(negedge clk)
    begin : drive_commands
        fifo_cmd_t nxt;
        if (rst_n && (!start || start_taken))
        begin
            if (gap_left == 0 && !quiet_tail && $urandom_range(0, 5) == 0)
                gap_left = $urandom_range(1, 11);
            if (gap_left > 0 || pending_cmds.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                start <= 1'b0;
            end
            else
            begin
                nxt = pending_cmds.pop_front();
                start          <= 1'b1;
                mode           <= nxt.mode;
                write_byte     <= nxt.data;
                request_length <= nxt.len;
            end
        end
    end

    // Monitor: checks results, tracks capacity writes and predicts each
    // accepted transaction.
    always @(posedge clk)
    begin : watch_results
        fifo_result_t got;
        fifo_result_t want;
        int unsigned  new_cap;
        fifo_cmd_t    c;
        if (rst_n)
        begin
            if (result_strobe)
            begin
                got = {read_byte, byte_valid, put_accepted, last_of_run,
                       occupancy, is_empty, is_full};
                if (due_results.size() == 0)
                    report_failure($sformatf("unexpected result byte=%02h valid=%b",
                                             got.rbyte, got.valid));
                else
                begin
                    want = due_results.pop_front();
                    results_checked++;
                    if (got !== want)
                        report_failure($sformatf(
                            {"byte/valid/acc/last/occ/empty/full expected ",
                             "%02h/%b/%b/%b/%0d/%b/%b got %02h/%b/%b/%b/%0d/%b/%b"},
                            want.rbyte, want.valid, want.accepted, want.last,
                            want.occ, want.empty, want.full,
                            got.rbyte, got.valid, got.accepted, got.last,
                            got.occ, got.empty, got.full));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                new_cap = 32'(cfg_data);
                if (new_cap == 0)
                    new_cap = 1;
                if (new_cap > brb_pkg::DEPTH_DEFAULT)
                    new_cap = brb_pkg::DEPTH_DEFAULT;
                cap    = new_cap;
                wr_idx = 0;
                rd_idx = 0;
                held   = 0;
                cap_writes++;
            end
            if (start && !busy)
            begin
                c = {mode, write_byte, request_length};
                compute_ring_results(c);
                mode_hits[mode]++;
            end
            start_taken <= start && !busy;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycle_count, due_results.size());
            $display("FAIL byte_ring_buffer_core");
            $finish;
        end
    end

    task automatic queue_cmd(input logic [brb_pkg::MODE_W-1:0] m,
                             input logic [brb_pkg::BYTE_W-1:0] d,
                             input logic [brb_pkg::LEN_W-1:0] len);
        fifo_cmd_t c;
        c.mode = m;
        c.data = d;
        c.len  = len;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_until_idle();
        while (pending_cmds.size() != 0 || start || due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [brb_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly put bursts followed by a read of a nearby length, with some
    // stray commands of any mode mixed in.
    task automatic queue_random_traffic(input int unsigned cap_eff,
                                        input int unsigned budget);
        int unsigned added;
        int unsigned burst;
        int unsigned k;
        int unsigned len;
        added = 0;
        while (added < budget)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                burst = $urandom_range(1, (cap_eff + 2 < 12) ? cap_eff + 2 : 12);
                for (k = 0; k < burst; k++)
                    queue_cmd(brb_pkg::MODE_PUT, brb_pkg::BYTE_W'($urandom_range(0, 255)),
                              brb_pkg::LEN_W'($urandom_range(0, 127)));
                len = ($urandom_range(0, 3) != 0) ? $urandom_range(0, burst + 2)
                                                  : $urandom_range(0, 127);
                queue_cmd($urandom_range(0, 1) ? brb_pkg::MODE_GET : brb_pkg::MODE_PEEK,
                          brb_pkg::BYTE_W'($urandom_range(0, 255)), brb_pkg::LEN_W'(len));
                added += burst + 1;
            end
            else
            begin
                queue_cmd(brb_pkg::MODE_W'($urandom_range(0, 3)),
                          brb_pkg::BYTE_W'($urandom_range(0, 255)),
                          brb_pkg::LEN_W'($urandom_range(0, 127)));
                added++;
            end
        end
    endtask

    initial
    begin
        int unsigned phase_caps [9];
        int unsigned ph;

        phase_caps = '{5, 2, 13, 1, 1024, 64, 1023, 3, 40};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset capacity: empty reads, boundary bytes, zero and long requests.
        queue_cmd(brb_pkg::MODE_GET, 8'h00, 7'd4);
        queue_cmd(brb_pkg::MODE_PEEK, 8'hFF, 7'd0);
        queue_cmd(MODE_UNUSED, 8'h00, 7'd0);
        queue_cmd(brb_pkg::MODE_PUT, 8'h00, 7'd127);
        queue_cmd(brb_pkg::MODE_PUT, 8'hFF, 7'd0);
        queue_cmd(brb_pkg::MODE_PUT, 8'h5A, 7'd0);
        queue_cmd(brb_pkg::MODE_PEEK, 8'h00, 7'd0);
        queue_cmd(brb_pkg::MODE_PEEK, 8'h00, 7'd127);
        queue_cmd(brb_pkg::MODE_GET, 8'h00, 7'd1);
        queue_cmd(brb_pkg::MODE_PUT, 8'hA5, 7'd0);
        queue_cmd(brb_pkg::MODE_GET, 8'h00, 7'd0);
        queue_cmd(brb_pkg::MODE_PEEK, 8'h00, 7'd2);
        queue_cmd(brb_pkg::MODE_GET, 8'h7F, 7'd127);
        queue_cmd(brb_pkg::MODE_GET, 8'h00, 7'd3);
        wait_until_idle();

        // A capacity of zero behaves as one byte: the second put is refused.
        write_capacity(11'd0);
        queue_cmd(brb_pkg::MODE_PUT, 8'h3C, 7'd0);
        queue_cmd(brb_pkg::MODE_PUT, 8'hC3, 7'd0);
        queue_cmd(brb_pkg::MODE_PEEK, 8'h00, 7'd1);
        queue_cmd(MODE_UNUSED, 8'hFF, 7'd127);
        queue_cmd(brb_pkg::MODE_GET, 8'h00, 7'd64);
        queue_cmd(brb_pkg::MODE_PUT, 8'h81, 7'd0);
        queue_cmd(brb_pkg::MODE_GET, 8'h00, 7'd1);
        wait_until_idle();

        // Over-range capacity clamps to the full store; requests above the
        // burst limit are cut to it.
        write_capacity(11'd2047);
        repeat (70)
            queue_cmd(brb_pkg::MODE_PUT, brb_pkg::BYTE_W'($urandom_range(0, 255)),
                      brb_pkg::LEN_W'($urandom_range(0, 127)));
        queue_cmd(brb_pkg::MODE_GET, brb_pkg::BYTE_W'($urandom_range(0, 255)), 7'd127);
        queue_cmd(brb_pkg::MODE_PEEK, brb_pkg::BYTE_W'($urandom_range(0, 255)), 7'd100);
        queue_cmd(brb_pkg::MODE_GET, brb_pkg::BYTE_W'($urandom_range(0, 255)), 7'd127);
        wait_until_idle();

        for (ph = 0; ph < 9; ph++)
        begin
            write_capacity(brb_pkg::CFG_W'(phase_caps[ph]));
            if (ph == 8)
                quiet_tail = 1'b1;
            queue_random_traffic(phase_caps[ph], 16);
            wait_until_idle();
        end

        repeat (10) @(posedge clk);
        $display("Checked %0d results from %0d put, %0d get, %0d peek, %0d unused-mode",
                 results_checked, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
        $display("commands across %0d capacity writes; %0d failures",
                 cap_writes, failure_count);
        if (failure_count == 0)
            $display("PASS byte_ring_buffer_core");
        else
            $display("FAIL byte_ring_buffer_core");
        $finish;
    end

endmodule

// ===== files.f =====
sv/brb_pkg.sv
sv/brb_ctrl.sv
sv/brb_datapath.sv
sv/byte_ring_buffer_core.sv
tb/byte_ring_buffer_core_tb.sv
